// ===== hdl/fdtd_e_field_update_stream_defines.svh =====
// ----------------------------------------------------------------------------
// FDTD E-field update stream: assertion macros
// Shared concurrent assertion forms used by the RTL of this block.
// ----------------------------------------------------------------------------
`ifndef FDTD_E_FIELD_UPDATE_STREAM_DEFINES_SVH
`define FDTD_E_FIELD_UPDATE_STREAM_DEFINES_SVH

// same-cycle implication
`define FDTD_E_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FDTD_E_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/fdtd_e_pkg.sv =====
// ----------------------------------------------------------------------------
// FDTD E-field update package
// Field widths, register indexes and the per-component result type.
// ----------------------------------------------------------------------------
package fdtd_e_pkg;

   localparam int FIELD_W = 32;
   localparam int CELL_W  = 6;
   localparam int CURL_W  = 34;   // difference of two 33-bit differences
   localparam int CSR_W   = 2;

   localparam logic [CSR_W-1:0] CSR_CELLS_X = 2'd0;
   localparam logic [CSR_W-1:0] CSR_CELLS_Y = 2'd1;
   localparam logic [CSR_W-1:0] CSR_CELLS_Z = 2'd2;

   localparam logic signed [FIELD_W-1:0] FIELD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [FIELD_W-1:0] FIELD_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic signed [FIELD_W-1:0] value;
      logic                      sat;
   } comp_result_type;

endpackage

// ===== hdl/fdtd_e_comp_update.sv =====
// ----------------------------------------------------------------------------
// FDTD E-field component update
// E' = round(Ca*E/2^30) + round(Cb*curl/2^16), clipped to 32 bits;
// pass-through when the component lies on the boundary.
// ----------------------------------------------------------------------------
module fdtd_e_comp_update (
   input  logic                                    upd,
   input  logic signed [fdtd_e_pkg::FIELD_W-1:0]   e_old,
   input  logic signed [fdtd_e_pkg::FIELD_W-1:0]   coef_a,
   input  logic        [fdtd_e_pkg::FIELD_W-1:0]   coef_b,
   input  logic signed [fdtd_e_pkg::CURL_W-1:0]    curl,
   output fdtd_e_pkg::comp_result_type             result
);

   localparam int PA_W  = 2 * fdtd_e_pkg::FIELD_W;
   localparam int PB_W  = fdtd_e_pkg::CURL_W + fdtd_e_pkg::FIELD_W + 1;
   localparam int TA_W  = 35;
   localparam int SUM_W = 48;

   localparam logic signed [PA_W:0]   HALF_A   = 65'sd536870912;        // 2^29
   localparam logic signed [PB_W-1:0] HALF_B   = 67'sd32768;            // 2^15
   localparam logic signed [PB_W-1:0] HUGE_POS = 67'sd4611686018427387904;
   localparam logic signed [PB_W-1:0] HUGE_NEG = -67'sd4611686018427387904;

   logic signed [PA_W-1:0]  prod_a;
   logic signed [PA_W:0]    ta_ext;
   logic signed [TA_W-1:0]  ta;
   logic signed [PB_W-1:0]  prod_b;
   logic signed [PB_W-1:0]  tb_ext;
   logic signed [SUM_W-1:0] tb;
   logic signed [SUM_W-1:0] sum;
   logic                    huge;

   assign prod_a = coef_a * e_old;
   assign ta_ext = PA_W'(prod_a) + HALF_A;
   assign ta     = TA_W'(ta_ext >>> 30);

   assign prod_b = curl * $signed({1'b0, coef_b});
   assign huge   = (prod_b >= HUGE_POS) || (prod_b <= HUGE_NEG);
   assign tb_ext = (prod_b + HALF_B) >>> 16;
   assign tb     = SUM_W'(tb_ext);

   assign sum = SUM_W'(ta) + tb;

   always_comb begin
      result.value = e_old;
      result.sat   = 1'b0;
      if (upd) begin
         if (huge) begin
            // product at or beyond 2^62 in magnitude always clips, toward the curl's sign
            result.sat   = 1'b1;
            result.value = curl[fdtd_e_pkg::CURL_W-1] ? fdtd_e_pkg::FIELD_MIN
                                                      : fdtd_e_pkg::FIELD_MAX;
         end else if (sum > SUM_W'(fdtd_e_pkg::FIELD_MAX)) begin
            result.sat   = 1'b1;
            result.value = fdtd_e_pkg::FIELD_MAX;
         end else if (sum < SUM_W'(fdtd_e_pkg::FIELD_MIN)) begin
            result.sat   = 1'b1;
            result.value = fdtd_e_pkg::FIELD_MIN;
         end else begin
            result.value = fdtd_e_pkg::FIELD_W'(sum);
         end
      end
   end

endmodule

// ===== hdl/fdtd_e_field_update_stream.sv =====
// An accepted request passes stage 1 and the result register to rsp_tvalid.
// Throughput: one grid point per cycle unless rsp_tready holds the output;
// the H neighbor stores are read and written at one address in the accept
// cycle (read-first), so they add no stall. Reset (synchronous): position
// and index counters clear, cells_x/y/z = 63, pipeline empties. Row and plane
// stores are not cleared; raster order writes each entry before use.
`include "fdtd_e_field_update_stream_defines.svh"

// ----------------------------------------------------------------------------
// FDTD E-field update stream
// Yee-grid E update, lossy dielectric, one raster-ordered point per request.
// ----------------------------------------------------------------------------
module fdtd_e_field_update_stream #(
   parameter int MAX_POINTS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   // h_x, h_y, h_z, e_x_old, e_y_old, e_z_old, coef_a, coef_b (32 bits each)
   input  logic [255:0]                      req_tdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // e_x_new, e_y_new, e_z_new (32 bits each)
   output logic [95:0]                       rsp_tdata,
   // saturated
   output logic                              rsp_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fdtd_e_pkg::CSR_W-1:0]      csr_index,
   input  logic [fdtd_e_pkg::CELL_W-1:0]     csr_data
);

   localparam int FW    = fdtd_e_pkg::FIELD_W;
   localparam int CW    = fdtd_e_pkg::CELL_W;
   localparam int KW    = fdtd_e_pkg::CURL_W;
   localparam int RK_W  = $clog2(MAX_POINTS);
   localparam int PL_N  = MAX_POINTS * MAX_POINTS;
   localparam int PL_W  = $clog2(PL_N);

   // request fields
   logic signed [FW-1:0] h_x, h_y, h_z;
   logic signed [FW-1:0] e_x_old, e_y_old, e_z_old, coef_a;
   logic        [FW-1:0] coef_b;

   assign h_x     = $signed(req_tdata[31:0]);
   assign h_y     = $signed(req_tdata[63:32]);
   assign h_z     = $signed(req_tdata[95:64]);
   assign e_x_old = $signed(req_tdata[127:96]);
   assign e_y_old = $signed(req_tdata[159:128]);
   assign e_z_old = $signed(req_tdata[191:160]);
   assign coef_a  = $signed(req_tdata[223:192]);
   assign coef_b  = req_tdata[255:224];

   // control
   logic [CW-1:0] cells_x_ff, cells_y_ff, cells_z_ff;
   logic [CW-1:0] cells_x_in, cells_y_in, cells_z_in;
   logic [CW-1:0] pos_i_ff, pos_j_ff, pos_k_ff;
   logic [CW-1:0] pos_i_in, pos_j_in, pos_k_in;
   logic [RK_W-1:0] rk_ff, rj_ff, rk_in, rj_in;
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic req_acc, advance, csr_hit;
   logic k_wrap, j_wrap, rk_top, rj_top;
   logic in_i, in_j, in_k, lo_i, lo_j, lo_k;

   logic [RK_W-1:0] row_addr;
   logic [PL_W-1:0] plane_addr;

   // stores
   logic signed [FW-1:0] hx_row_mem   [MAX_POINTS];
   logic signed [FW-1:0] hz_row_mem   [MAX_POINTS];
   logic signed [FW-1:0] hy_plane_mem [PL_N];
   logic signed [FW-1:0] hz_plane_mem [PL_N];

   // stage 1
   logic signed [FW-1:0] hx_prev_ff, hy_prev_ff;
   logic signed [FW-1:0] hx_row_ff, hz_row_ff, hy_plane_ff, hz_plane_ff;
   logic signed [FW-1:0] hx_s1_ff, hy_s1_ff, hz_s1_ff, hxp_s1_ff, hyp_s1_ff;
   logic signed [FW-1:0] ex_s1_ff, ey_s1_ff, ez_s1_ff, ca_s1_ff;
   logic        [FW-1:0] cb_s1_ff;
   logic                 upd_x_s1_ff, upd_y_s1_ff, upd_z_s1_ff;

   logic signed [KW-1:0] curl_x, curl_y, curl_z;
   fdtd_e_pkg::comp_result_type res_x, res_y, res_z;

   // result register
   logic [95:0] rsp_data_ff;
   logic        rsp_sat_ff;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign in_i = pos_i_ff < cells_x_ff;
   assign in_j = pos_j_ff < cells_y_ff;
   assign in_k = pos_k_ff < cells_z_ff;
   assign lo_i = pos_i_ff != '0;
   assign lo_j = pos_j_ff != '0;
   assign lo_k = pos_k_ff != '0;

   assign k_wrap = !in_k;
   assign j_wrap = !in_j;
   assign rk_top = rk_ff == RK_W'(MAX_POINTS - 1);
   assign rj_top = rj_ff == RK_W'(MAX_POINTS - 1);

   assign row_addr   = rk_ff;
   assign plane_addr = PL_W'(rj_ff) * PL_W'(MAX_POINTS) + PL_W'(rk_ff);

   // configuration decode and position advance
   always_comb begin
      cells_x_in = cells_x_ff;
      cells_y_in = cells_y_ff;
      cells_z_in = cells_z_ff;
      csr_hit    = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            fdtd_e_pkg::CSR_CELLS_X: begin
               cells_x_in = csr_data;
               csr_hit    = 1'b1;
            end
            fdtd_e_pkg::CSR_CELLS_Y: begin
               cells_y_in = csr_data;
               csr_hit    = 1'b1;
            end
            fdtd_e_pkg::CSR_CELLS_Z: begin
               cells_z_in = csr_data;
               csr_hit    = 1'b1;
            end
            default: csr_hit = 1'b0;
         endcase
      end

      pos_i_in = pos_i_ff;
      pos_j_in = pos_j_ff;
      pos_k_in = pos_k_ff;
      rk_in    = rk_ff;
      rj_in    = rj_ff;
      if (csr_hit) begin
         pos_i_in = '0;
         pos_j_in = '0;
         pos_k_in = '0;
         rk_in    = '0;
         rj_in    = '0;
      end else if (req_acc) begin
         if (!k_wrap) begin
            pos_k_in = pos_k_ff + 1'b1;
            rk_in    = rk_top ? '0 : rk_ff + 1'b1;
         end else begin
            pos_k_in = '0;
            rk_in    = '0;
            if (!j_wrap) begin
               pos_j_in = pos_j_ff + 1'b1;
               rj_in    = rj_top ? '0 : rj_ff + 1'b1;
            end else begin
               pos_j_in = '0;
               rj_in    = '0;
               pos_i_in = in_i ? pos_i_ff + 1'b1 : '0;
            end
         end
      end

      s1_valid_in = req_acc ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_x_ff   <= 6'd63;
         cells_y_ff   <= 6'd63;
         cells_z_ff   <= 6'd63;
         pos_i_ff     <= '0;
         pos_j_ff     <= '0;
         pos_k_ff     <= '0;
         rk_ff        <= '0;
         rj_ff        <= '0;
         hx_prev_ff   <= '0;
         hy_prev_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cells_x_ff   <= cells_x_in;
         cells_y_ff   <= cells_y_in;
         cells_z_ff   <= cells_z_in;
         pos_i_ff     <= pos_i_in;
         pos_j_ff     <= pos_j_in;
         pos_k_ff     <= pos_k_in;
         rk_ff        <= rk_in;
         rj_ff        <= rj_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_acc) begin
            hx_prev_ff <= h_x;
            hy_prev_ff <= h_y;
         end
      end
   end

   // read-first stores: old entry goes to stage 1, new H overwrites it
   always_ff @(posedge clock) begin
      if (req_acc) begin
         hx_row_ff            <= hx_row_mem[row_addr];
         hx_row_mem[row_addr] <= h_x;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         hz_row_ff            <= hz_row_mem[row_addr];
         hz_row_mem[row_addr] <= h_z;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         hy_plane_ff                <= hy_plane_mem[plane_addr];
         hy_plane_mem[plane_addr]   <= h_y;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         hz_plane_ff                <= hz_plane_mem[plane_addr];
         hz_plane_mem[plane_addr]   <= h_z;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         hx_s1_ff    <= h_x;
         hy_s1_ff    <= h_y;
         hz_s1_ff    <= h_z;
         hxp_s1_ff   <= hx_prev_ff;
         hyp_s1_ff   <= hy_prev_ff;
         ex_s1_ff    <= e_x_old;
         ey_s1_ff    <= e_y_old;
         ez_s1_ff    <= e_z_old;
         ca_s1_ff    <= coef_a;
         cb_s1_ff    <= coef_b;
         upd_x_s1_ff <= in_i && in_j && lo_j && in_k && lo_k;
         upd_y_s1_ff <= in_i && lo_i && in_j && in_k && lo_k;
         upd_z_s1_ff <= in_i && lo_i && in_j && lo_j && in_k;
      end
   end

   assign curl_x = (KW'(hz_s1_ff) - KW'(hz_row_ff)) - (KW'(hy_s1_ff) - KW'(hyp_s1_ff));
   assign curl_y = (KW'(hx_s1_ff) - KW'(hxp_s1_ff)) - (KW'(hz_s1_ff) - KW'(hz_plane_ff));
   assign curl_z = (KW'(hy_s1_ff) - KW'(hy_plane_ff)) - (KW'(hx_s1_ff) - KW'(hx_row_ff));

   fdtd_e_comp_update u_upd_x (
      .upd    (upd_x_s1_ff),
      .e_old  (ex_s1_ff),
      .coef_a (ca_s1_ff),
      .coef_b (cb_s1_ff),
      .curl   (curl_x),
      .result (res_x)
   );

   fdtd_e_comp_update u_upd_y (
      .upd    (upd_y_s1_ff),
      .e_old  (ey_s1_ff),
      .coef_a (ca_s1_ff),
      .coef_b (cb_s1_ff),
      .curl   (curl_y),
      .result (res_y)
   );

   fdtd_e_comp_update u_upd_z (
      .upd    (upd_z_s1_ff),
      .e_old  (ez_s1_ff),
      .coef_a (ca_s1_ff),
      .coef_b (cb_s1_ff),
      .curl   (curl_z),
      .result (res_z)
   );

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_data_ff <= {res_z.value, res_y.value, res_x.value};
         rsp_sat_ff  <= res_x.sat || res_y.sat || res_z.sat;
      end
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;
   assign rsp_tvalid = rsp_valid_ff;

   `FDTD_E_ASSERT_IMP(a_pos_k_range, clock, reset, 1'b1, pos_k_ff <= cells_z_ff, "pos_k past cells_z")
   `FDTD_E_ASSERT_IMP(a_pos_j_range, clock, reset, 1'b1, pos_j_ff <= cells_y_ff, "pos_j past cells_y")
   `FDTD_E_ASSERT_IMP(a_row_idx_sync, clock, reset, pos_k_ff == '0, rk_ff == '0, "row index out of step")
   `FDTD_E_ASSERT_NXT(a_s1_hold, clock, reset, s1_valid_ff && !advance, s1_valid_ff, "stage 1 lost")
   `FDTD_E_ASSERT_IMP(a_rsp_src, clock, reset, $rose(rsp_valid_ff), $past(s1_valid_ff), "result from empty stage")

endmodule
